/* hdl/jss_pkg.sv */
// jss_pkg: shared types and constants of the jacobi stencil sweep block
`default_nettype none

package jss_pkg;

  localparam int DATA_W  = 32;
  localparam int COLS_W  = 10;
  localparam int ROWS_W  = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(16);
  localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(16);

  // configuration register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } cfg_reg_e;

  // one line store entry: the row two above and the row just above
  typedef struct packed {
    logic [DATA_W-1:0] upper;
    logic [DATA_W-1:0] middle;
  } line_word_t;

  // line store control from the raster counters
  typedef struct packed {
    logic accept;
    logic wrap;
  } ls_ctrl_t;

  // per result tag that travels with the update pipeline
  typedef struct packed {
    logic last;
    logic fresh;
  } upd_tag_t;

endpackage

`default_nettype wire

/* hdl/jss_in_if.sv */
// jss_in_if: request channel carrying one old grid cell
`default_nettype none

interface jss_in_if import jss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] old_value;

  modport source (output valid, output old_value, input ready);
  modport sink   (input valid, input old_value, output ready);
endinterface

`default_nettype wire

/* hdl/jss_out_if.sv */
// jss_out_if: request channel carrying one updated interior cell
`default_nettype none

interface jss_out_if import jss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_value;
  logic        [DATA_W-1:0] max_diff;
  logic                     sweep_last;

  modport source (output valid, output new_value, output max_diff, output sweep_last,
                  input ready);
  modport sink   (input valid, input new_value, input max_diff, input sweep_last,
                  output ready);
endinterface

`default_nettype wire

/* hdl/jss_cfg.sv */
// jss_cfg: apb register file holding the grid dimensions
`default_nettype none

module jss_cfg import jss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [COLS_W-1:0]  cols_o,
  output logic      [ROWS_W-1:0]  rows_o
);

  logic [COLS_W-1:0] cols_q, cols_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  cfg_reg_e          sel;
  logic              wr_en;

  assign pready = 1'b1;
  assign sel    = cfg_reg_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (wr_en) begin
      case (sel)
        REG_COLS: cols_d = pwdata[COLS_W-1:0];
        REG_ROWS: rows_d = pwdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RST;
      rows_q <= ROWS_RST;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_COLS: prdata = PDATA_W'(cols_q);
      REG_ROWS: prdata = PDATA_W'(rows_q);
      default:  prdata = '0;
    endcase
  end

  assign cols_o = cols_q;
  assign rows_o = rows_q;

endmodule

`default_nettype wire

/* hdl/jss_line_store.sv */
// jss_line_store: two line memory with read-ahead window and reset clearing pass
`default_nettype none

module jss_line_store import jss_pkg::*; #(
  parameter int LINE_DEPTH = 1024,
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ls_ctrl_t          ctrl_i,
  input  wire logic [AW-1:0]     col_i,
  input  wire logic [DATA_W-1:0] cell_i,
  output logic                   busy_o,
  output logic      [DATA_W-1:0] centre_o,
  output logic      [DATA_W-1:0] upper_o,
  output logic      [DATA_W-1:0] right_o,
  output logic      [DATA_W-1:0] left_o
);

  line_word_t mem [LINE_DEPTH];

  logic       busy_q, busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic       use_head_q, use_head_d;
  logic       clr_done;

  line_word_t rdata_q, cur_q, head0_q, head1_q;
  logic [DATA_W-1:0] left_q;
  line_word_t ahead, wr_word;
  logic [AW-1:0] rd_addr;

  // the word after the current column: from memory, or the row head copy after a wrap
  assign ahead          = use_head_q ? head1_q : rdata_q;
  assign wr_word.upper  = cur_q.middle;
  assign wr_word.middle = cell_i;
  assign rd_addr        = col_i + AW'(2);
  assign clr_done       = busy_q && (clr_addr_q == AW'(LINE_DEPTH - 1));

  // clearing pass and head select control
  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    use_head_d = use_head_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_done) begin
        busy_d     = 1'b0;
        use_head_d = 1'b1;
      end
    end else if (ctrl_i.accept) begin
      use_head_d = ctrl_i.wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
      use_head_q <= 1'b1;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
      use_head_q <= use_head_d;
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (ctrl_i.accept) begin
      mem[col_i] <= wr_word;
    end
  end

  // memory read port and window registers
  always_ff @(posedge clk_i) begin
    if (!busy_q && ctrl_i.accept) begin
      rdata_q <= mem[rd_addr];
      cur_q   <= ctrl_i.wrap ? head0_q : ahead;
      left_q  <= cur_q.middle;
      if (col_i == AW'(0)) begin
        head0_q <= wr_word;
      end
      if (col_i == AW'(1)) begin
        head1_q <= wr_word;
      end
    end else if (clr_done) begin
      cur_q   <= '0;
      head1_q <= '0;
    end
  end

  assign busy_o   = busy_q;
  assign centre_o = cur_q.middle;
  assign upper_o  = cur_q.upper;
  assign right_o  = ahead.middle;
  assign left_o   = left_q;

endmodule

`default_nettype wire

/* hdl/jss_update.sv */
// jss_update: three stage pipeline for the stencil sum, change and running maximum
`default_nettype none

module jss_update import jss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire upd_tag_t          tag_i,
  input  wire logic [DATA_W-1:0] centre_i,
  input  wire logic [DATA_W-1:0] upper_i,
  input  wire logic [DATA_W-1:0] left_i,
  input  wire logic [DATA_W-1:0] right_i,
  input  wire logic [DATA_W-1:0] cell_i,
  output logic                   ready_o,
  jss_out_if.source              out_o
);

  localparam int SUM_W = DATA_W + 2;

  // stage 1: new value
  logic              s1_v_q;
  upd_tag_t          s1_tag_q;
  logic [DATA_W-1:0] s1_nv_q, s1_centre_q;
  // stage 2: absolute change
  logic              s2_v_q;
  upd_tag_t          s2_tag_q;
  logic [DATA_W-1:0] s2_nv_q, s2_ad_q;
  // output register
  logic              o_v_q;
  logic              o_last_q;
  logic [DATA_W-1:0] o_nv_q, o_max_q;

  logic o_rdy, s2_rdy, s1_rdy;
  logic [SUM_W-1:0]  sum;
  logic [DATA_W:0]   d_pos, d_neg;
  logic [DATA_W-1:0] ad, base, max_d;

  assign o_rdy   = !o_v_q || out_o.ready;
  assign s2_rdy  = !s2_v_q || o_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign ready_o = s1_rdy;

  // four neighbour sum, floor divide by four
  assign sum = {{2{upper_i[DATA_W-1]}}, upper_i} + {{2{left_i[DATA_W-1]}}, left_i}
             + {{2{right_i[DATA_W-1]}}, right_i} + {{2{cell_i[DATA_W-1]}}, cell_i};

  // both differences in parallel, keep the non-negative one
  assign d_pos = {s1_centre_q[DATA_W-1], s1_centre_q} - {s1_nv_q[DATA_W-1], s1_nv_q};
  assign d_neg = {s1_nv_q[DATA_W-1], s1_nv_q} - {s1_centre_q[DATA_W-1], s1_centre_q};
  assign ad    = d_pos[DATA_W] ? d_neg[DATA_W-1:0] : d_pos[DATA_W-1:0];

  // running maximum restarts on the first result of a sweep
  assign base  = s2_tag_q.fresh ? '0 : o_max_q;
  assign max_d = (s2_ad_q > base) ? s2_ad_q : base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= req_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (o_rdy)  o_v_q  <= s2_v_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_valid_i) begin
      s1_tag_q    <= tag_i;
      s1_nv_q     <= sum[SUM_W-1:2];
      s1_centre_q <= centre_i;
    end
    if (s2_rdy && s1_v_q) begin
      s2_tag_q <= s1_tag_q;
      s2_nv_q  <= s1_nv_q;
      s2_ad_q  <= ad;
    end
    if (o_rdy && s2_v_q) begin
      o_last_q <= s2_tag_q.last;
      o_nv_q   <= s2_nv_q;
      o_max_q  <= max_d;
    end
  end

  assign out_o.valid      = o_v_q;
  assign out_o.new_value  = o_nv_q;
  assign out_o.max_diff   = o_max_q;
  assign out_o.sweep_last = o_last_q;

endmodule

`default_nettype wire

/* hdl/jacobi_stencil_sweep.sv */
// jacobi_stencil_sweep: top level of the five point jacobi sweep over a raster cell stream
// one cell per cycle unless stalled, bounded by the single write and read port of line memory
// after the cell below it is accepted, a result passes stage 1, stage 2 and the output register
// cells without a result are accepted and produce nothing
// reset: after rst_ni releases, a clearing pass zeroes the line memory;
// no cell is accepted during it, register writes are taken as usual
`default_nettype none

module jacobi_stencil_sweep import jss_pkg::*; #(
  parameter int LINE_DEPTH = 1024,
  parameter int MAX_ROWS   = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  jss_in_if.sink                  in_i,
  jss_out_if.source               out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int RW  = $clog2(MAX_ROWS + 2);
  localparam int CXW = ((AW > COLS_W) ? AW : COLS_W) + 1;
  localparam int RXW = ((RW > ROWS_W) ? RW : ROWS_W) + 1;

  logic [COLS_W-1:0] cfg_cols;
  logic [ROWS_W-1:0] cfg_rows;
  logic [CXW-1:0]    cols_ext;
  logic [RXW-1:0]    rows_ext;
  logic [AW-1:0]     cols_eff, last_col;
  logic [RW-1:0]     rows_eff, last_row;

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          fresh_q, fresh_d;

  logic     in_accept, wrap, sweep_end, is_result, is_last;
  logic     ls_busy, upd_ready;
  ls_ctrl_t ls_ctrl;
  upd_tag_t tag;
  logic [DATA_W-1:0] centre, upper, right, left;

  jss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cols_o  (cfg_cols),
    .rows_o  (cfg_rows)
  );

  // clamp the programmed sizes to what the storage supports
  always_comb begin
    cols_ext = CXW'(cfg_cols);
    if (cols_ext == '0) begin
      cols_ext = CXW'(1);
    end else if (cols_ext > CXW'(LINE_DEPTH - 2)) begin
      cols_ext = CXW'(LINE_DEPTH - 2);
    end
    rows_ext = RXW'(cfg_rows);
    if (rows_ext == '0) begin
      rows_ext = RXW'(1);
    end else if (rows_ext > RXW'(MAX_ROWS)) begin
      rows_ext = RXW'(MAX_ROWS);
    end
  end

  assign cols_eff = cols_ext[AW-1:0];
  assign rows_eff = rows_ext[RW-1:0];
  assign last_col = cols_eff + AW'(1);
  assign last_row = rows_eff + RW'(1);

  // raster position decode
  assign in_accept = in_i.valid && in_i.ready;
  assign wrap      = col_q >= last_col;
  assign sweep_end = wrap && (row_q >= last_row);
  assign is_result = (row_q >= RW'(2)) && (col_q != '0) && (col_q <= cols_eff);
  assign is_last   = (row_q == last_row) && (col_q == cols_eff);

  assign in_i.ready = !ls_busy && upd_ready;

  // position counters and sweep start flag
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    fresh_d = fresh_q;
    if (in_accept) begin
      if (is_result) begin
        fresh_d = 1'b0;
      end
      if (wrap) begin
        col_d = '0;
        if (sweep_end) begin
          row_d   = '0;
          fresh_d = 1'b1;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      fresh_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      fresh_q <= fresh_d;
    end
  end

  assign ls_ctrl.accept = in_accept;
  assign ls_ctrl.wrap   = wrap;

  jss_line_store #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ls_ctrl),
    .col_i    (col_q),
    .cell_i   (in_i.old_value),
    .busy_o   (ls_busy),
    .centre_o (centre),
    .upper_o  (upper),
    .right_o  (right),
    .left_o   (left)
  );

  assign tag.last  = is_last;
  assign tag.fresh = fresh_q;

  jss_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_accept && is_result),
    .tag_i       (tag),
    .centre_i    (centre),
    .upper_i     (upper),
    .left_i      (left),
    .right_i     (right),
    .cell_i      (in_i.old_value),
    .ready_o     (upd_ready),
    .out_o       (out_o)
  );

  // no cell is taken while the line memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_busy |-> !(in_i.valid && in_i.ready))
    else $error("cell accepted during clearing pass");

  // the raster position stays at the origin through the clearing pass
  a_origin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_busy |-> (col_q == '0) && (row_q == '0))
    else $error("raster position moved during clearing pass");

  // the end of a sweep returns to the origin and rearms the maximum
  a_sweep_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && sweep_end) |=> (col_q == '0) && (row_q == '0) && fresh_q)
    else $error("sweep did not restart at the origin");

endmodule

`default_nettype wire
